// ----- src/rdsrt_pkg.sv -----
// Package for the RDS RadioText assembler.
// Holds the word types of both channels, the controller/datapath command and
// status structs, and the fixed RDS constants. No dependencies.
package rdsrt_pkg;

  localparam logic [4:0] GTYPE_2A = 5'h04;
  localparam logic [4:0] GTYPE_2B = 5'h05;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [6:0] MIN_FLUSH = 7'd8;

  typedef struct packed {
    logic [15:0] block_b;
    logic [15:0] block_c;
    logic [15:0] block_d;
  } grp_t;

  typedef struct packed {
    logic [7:0] char_first;
    logic [7:0] char_second;
    logic [7:0] char_third;
    logic [7:0] char_fourth;
    logic [2:0] char_count;
    logic       last_word;
  } txt_t;

  typedef struct packed {
    logic       latch;
    logic       clear;
    logic       char_step;
    logic [1:0] char_sel;
    logic       emit_init;
    logic       rd_issue;
    logic       out_load;
    logic       word_reset;
  } dp_cmd_t;

  typedef struct packed {
    logic mode_a;
    logic type_ok;
    logic pos_zero;
    logic pos_match;
    logic flush_due;
    logic char_end;
    logic empty;
    logic lane_full;
    logic ptr_last;
    logic word_last;
    logic out_free;
  } dp_sts_t;

endpackage

// ----- src/rds_radiotext_assembler_top.sv -----
// Top level of the RDS RadioText assembler.
// Depends on rdsrt_pkg, rdsrt_ctrl and rdsrt_datapath.
//
// The grp channel takes one RDS group (blocks B, C and D) per word with
// grp_valid and grp_stall. Groups of the type that cfg_data last wrote with
// cfg_we selects (1 for 2A, 0 for 2B) are collected as RadioText. Each
// finished message leaves on the txt channel as words of up to four
// characters, trimmed of leading and trailing whitespace, with last_word set
// on the final one; an empty message is one word with char_count 0.
// Emission reads each output word from the text memory one character per
// cycle, then drains the last read and loads the output register. The block
// works on one group at a time and holds grp_stall high until it is done.
// While txt_valid and txt_stall are both high the output register keeps its
// word and emission waits. Synchronous reset sets the mode to 2A, empties the
// text buffer and leaves both channels idle; the block accepts a group in the
// first cycle after reset.
module rds_radiotext_assembler_top #(
  parameter int TEXT_DEPTH = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            grp_valid,
  output logic            grp_stall,
  input  rdsrt_pkg::grp_t grp,
  output logic            txt_valid,
  input  logic            txt_stall,
  output rdsrt_pkg::txt_t txt,
  input  logic            cfg_we,
  input  logic            cfg_data
);

  rdsrt_pkg::dp_cmd_t cmd;
  rdsrt_pkg::dp_sts_t sts;

  rdsrt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .grp_valid (grp_valid),
    .grp_stall (grp_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  rdsrt_datapath #(
    .TEXT_DEPTH (TEXT_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .grp       (grp),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .txt_valid (txt_valid),
    .txt_stall (txt_stall),
    .txt       (txt)
  );

endmodule

// ----- src/rdsrt_datapath.sv -----
// Datapath of the RDS RadioText assembler: group register, mode register,
// text memory, fill and trim trackers, word assembly and the output register.
// Depends on rdsrt_pkg; driven by rdsrt_ctrl through command and status.
module rdsrt_datapath #(
  parameter int TEXT_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  rdsrt_pkg::grp_t    grp,
  input  logic               cfg_we,
  input  logic               cfg_data,
  input  rdsrt_pkg::dp_cmd_t cmd,
  output rdsrt_pkg::dp_sts_t sts,
  output logic               txt_valid,
  input  logic               txt_stall,
  output rdsrt_pkg::txt_t    txt
);

  localparam int AW = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
  localparam logic [6:0] DEPTH_FULL = 7'(TEXT_DEPTH);
  localparam logic [6:0] DEPTH_HALF = 7'(TEXT_DEPTH / 2);

  function automatic logic is_space(input logic [7:0] ch);
    is_space = (ch == 8'h20) || ((ch >= 8'h09) && (ch <= 8'h0D));
  endfunction

  logic                mode_a;
  rdsrt_pkg::grp_t     grp_q;
  logic [7:0]          text_mem [TEXT_DEPTH];
  logic [7:0]          rdata;
  logic [6:0]          fill;
  logic                seen;
  logic [6:0]          first_pos;
  logic [6:0]          end_pos;
  logic [6:0]          ptr;
  logic [2:0]          nchars;
  logic                pend;
  logic [1:0]          pend_lane;
  logic [7:0]          word [4];

  logic [7:0] ch_raw;
  logic [7:0] ch;
  logic [6:0] fill_inc;
  logic [6:0] max_len;
  logic [5:0] pos;
  logic       in_range;

  always_comb begin
    unique case (cmd.char_sel)
      2'd0: ch_raw = grp_q.block_c[15:8];
      2'd1: ch_raw = grp_q.block_c[7:0];
      2'd2: ch_raw = grp_q.block_d[15:8];
      default: ch_raw = grp_q.block_d[7:0];
    endcase
  end

  assign ch = (ch_raw == rdsrt_pkg::CHAR_CR) ? 8'h00 : ch_raw;
  assign fill_inc = fill + 7'd1;
  assign max_len = mode_a ? DEPTH_FULL : DEPTH_HALF;
  assign pos = mode_a ? {grp_q.block_b[3:0], 2'b00} : {1'b0, grp_q.block_b[3:0], 1'b0};
  assign in_range = fill < DEPTH_FULL;

  always_comb begin
    sts.mode_a    = mode_a;
    sts.type_ok   = grp_q.block_b[15:11] == (mode_a ? rdsrt_pkg::GTYPE_2A
                                                    : rdsrt_pkg::GTYPE_2B);
    sts.pos_zero  = pos == 6'd0;
    sts.pos_match = {1'b0, pos} == fill;
    sts.flush_due = fill >= rdsrt_pkg::MIN_FLUSH;
    sts.char_end  = (ch == 8'h00) || (fill_inc >= max_len);
    sts.empty     = !seen;
    sts.lane_full = nchars == 3'd3;
    sts.ptr_last  = (ptr + 7'd1) == end_pos;
    sts.word_last = !seen || (ptr == end_pos);
    sts.out_free  = !txt_valid || !txt_stall;
  end

  always_ff @(posedge clk) begin
    if (cmd.char_step && in_range) begin
      text_mem[fill[AW-1:0]] <= ch;
    end
    if (cmd.rd_issue) begin
      rdata <= text_mem[ptr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      grp_q <= grp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_a <= 1'b1;
      fill <= '0;
      seen <= 1'b0;
      pend <= 1'b0;
      txt_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode_a <= cfg_data;
      end
      if (cmd.clear) begin
        fill <= '0;
        seen <= 1'b0;
      end else if (cmd.char_step) begin
        fill <= fill_inc;
        if (in_range && (ch != 8'h00) && !is_space(ch)) begin
          seen <= 1'b1;
        end
      end
      pend <= cmd.rd_issue;
      if (cmd.out_load) begin
        txt_valid <= 1'b1;
      end else if (!txt_stall) begin
        txt_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.char_step && in_range && (ch != 8'h00) && !is_space(ch)) begin
      if (!seen) begin
        first_pos <= fill;
      end
      end_pos <= fill_inc;
    end
    if (cmd.emit_init) begin
      ptr <= first_pos;
    end else if (cmd.rd_issue) begin
      ptr <= ptr + 7'd1;
    end
    if (cmd.rd_issue) begin
      pend_lane <= nchars[1:0];
    end
    if (cmd.emit_init || cmd.word_reset) begin
      nchars <= '0;
      for (int i = 0; i < 4; i++) begin
        word[i] <= 8'h00;
      end
    end else begin
      if (cmd.rd_issue) begin
        nchars <= nchars + 3'd1;
      end
      if (pend) begin
        word[pend_lane] <= rdata;
      end
    end
    if (cmd.out_load) begin
      txt.char_first  <= word[0];
      txt.char_second <= word[1];
      txt.char_third  <= word[2];
      txt.char_fourth <= word[3];
      txt.char_count  <= nchars;
      txt.last_word   <= sts.word_last;
    end
  end

endmodule

// ----- src/rdsrt_ctrl.sv -----
// Controller of the RDS RadioText assembler: a one-hot state machine that
// sequences group checks, character stores and word emission.
// Depends on rdsrt_pkg; drives rdsrt_datapath through command and status.
module rdsrt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               grp_valid,
  output logic               grp_stall,
  input  rdsrt_pkg::dp_sts_t sts,
  output rdsrt_pkg::dp_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE       = 7'b0000001,
    S_CHECK      = 7'b0000010,
    S_CHAR       = 7'b0000100,
    S_EMIT_INIT  = 7'b0001000,
    S_EMIT_READ  = 7'b0010000,
    S_EMIT_DRAIN = 7'b0100000,
    S_EMIT_OUT   = 7'b1000000
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [1:0] char_idx;
  logic [1:0] char_idx_next;
  logic       flush_ctx;
  logic       flush_ctx_next;
  logic [1:0] char_start;

  assign char_start = sts.mode_a ? 2'd0 : 2'd2;
  assign grp_stall = state != S_IDLE;

  always_comb begin
    state_next = state;
    char_idx_next = char_idx;
    flush_ctx_next = flush_ctx;
    cmd = '0;
    cmd.char_sel = char_idx;
    unique case (state)
      S_IDLE: begin
        if (grp_valid) begin
          cmd.latch = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (!sts.type_ok) begin
          state_next = S_IDLE;
        end else if (sts.pos_zero && sts.flush_due) begin
          flush_ctx_next = 1'b1;
          state_next = S_EMIT_INIT;
        end else if (sts.pos_zero || sts.pos_match) begin
          cmd.clear = sts.pos_zero;
          char_idx_next = char_start;
          state_next = S_CHAR;
        end else begin
          cmd.clear = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_CHAR: begin
        cmd.char_step = 1'b1;
        priority if (sts.char_end) begin
          flush_ctx_next = 1'b0;
          state_next = S_EMIT_INIT;
        end else if (char_idx == 2'd3) begin
          state_next = S_IDLE;
        end else begin
          char_idx_next = char_idx + 2'd1;
        end
      end
      S_EMIT_INIT: begin
        cmd.emit_init = 1'b1;
        state_next = sts.empty ? S_EMIT_OUT : S_EMIT_READ;
      end
      S_EMIT_READ: begin
        cmd.rd_issue = 1'b1;
        if (sts.lane_full || sts.ptr_last) begin
          state_next = S_EMIT_DRAIN;
        end
      end
      S_EMIT_DRAIN: begin
        state_next = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.word_reset = 1'b1;
          if (sts.word_last) begin
            cmd.clear = 1'b1;
            if (flush_ctx) begin
              char_idx_next = char_start;
              state_next = S_CHAR;
            end else begin
              state_next = S_IDLE;
            end
          end else begin
            state_next = S_EMIT_READ;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      char_idx <= '0;
      flush_ctx <= 1'b0;
    end else begin
      state <= state_next;
      char_idx <= char_idx_next;
      flush_ctx <= flush_ctx_next;
    end
  end

endmodule
